// File: src/wavhdr_pkg.sv
package wavhdr_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_FAIL  = 1'b1;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } wavhdr_in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] chunk_bytes;
    logic [31:0] payload_pos;
  } wavhdr_out_t;

  typedef struct packed {
    logic       step;
    wavhdr_in_t item;
  } wavhdr_req_t;

  typedef struct packed {
    logic        res_valid;
    wavhdr_out_t res;
  } wavhdr_rsp_t;

endpackage

// File: src/wavhdr_core.sv
module wavhdr_core (
  input  logic                  clk,
  input  logic                  rst,
  input  wavhdr_pkg::wavhdr_req_t req,
  output wavhdr_pkg::wavhdr_rsp_t rsp
);
  import wavhdr_pkg::*;

  phase_t      phase, phase_next, cur_phase;
  logic [3:0]  cnt, cnt_next, cur_cnt;
  logic [31:0] tag_shift, tag_shift_next, cur_tag;
  logic [31:0] size_accum, size_accum_next, cur_size;
  logic [31:0] skip_left, skip_left_next, cur_skip;
  logic [15:0] channels_held, channels_held_next, cur_ch;
  logic [31:0] rate_held, rate_held_next, cur_rate;
  logic [15:0] width_held, width_held_next, cur_width;
  logic [31:0] file_position, file_position_next, cur_pos;
  logic        finished, finished_next, cur_fin;
  logic        found, fail;
  logic [7:0]  d;

  always_comb begin
    d = req.item.data_byte;
    if (req.item.first_byte) begin
      cur_phase = PH_RIFF;
      cur_cnt   = '0;
      cur_tag   = '0;
      cur_size  = '0;
      cur_skip  = '0;
      cur_ch    = '0;
      cur_rate  = '0;
      cur_width = '0;
      cur_pos   = '0;
      cur_fin   = 1'b0;
    end else begin
      cur_phase = phase;
      cur_cnt   = cnt;
      cur_tag   = tag_shift;
      cur_size  = size_accum;
      cur_skip  = skip_left;
      cur_ch    = channels_held;
      cur_rate  = rate_held;
      cur_width = width_held;
      cur_pos   = file_position;
      cur_fin   = finished;
    end

    phase_next         = cur_phase;
    cnt_next           = cur_cnt;
    tag_shift_next     = cur_tag;
    size_accum_next    = cur_size;
    skip_left_next     = cur_skip;
    channels_held_next = cur_ch;
    rate_held_next     = cur_rate;
    width_held_next    = cur_width;
    file_position_next = cur_pos;
    finished_next      = cur_fin;
    found              = 1'b0;
    fail               = 1'b0;

    if (!cur_fin) begin
      file_position_next = cur_pos + 32'd1;
      case (cur_phase)
        PH_RIFF: begin
          tag_shift_next = {cur_tag[23:0], d};
          if (cur_cnt == 4'd3 && tag_shift_next != TAG_RIFF) begin
            fail = 1'b1;
          end else if (cur_cnt == 4'd11) begin
            if (tag_shift_next != TAG_WAVE) begin
              fail = 1'b1;
            end else begin
              phase_next = PH_HDR;
              cnt_next   = '0;
            end
          end else begin
            cnt_next = cur_cnt + 4'd1;
          end
        end
        PH_HDR: begin
          if (cur_cnt < 4'd4) begin
            tag_shift_next = {cur_tag[23:0], d};
          end else begin
            size_accum_next = {d, cur_size[31:8]};
          end
          if (cur_cnt == 4'd7) begin
            cnt_next = '0;
            if (tag_shift_next == TAG_FMT) begin
              if (size_accum_next < FMT_MIN) begin
                fail = 1'b1;
              end else begin
                skip_left_next = size_accum_next - FMT_MIN;
                phase_next     = PH_FMT;
              end
            end else if (tag_shift_next == TAG_DATA) begin
              found = 1'b1;
            end else if (size_accum_next != '0) begin
              skip_left_next = size_accum_next;
              phase_next     = PH_SKIP;
            end
          end else begin
            cnt_next = cur_cnt + 4'd1;
          end
        end
        PH_FMT: begin
          case (cur_cnt)
            4'd2:    channels_held_next[7:0]  = d;
            4'd3:    channels_held_next[15:8] = d;
            4'd4:    rate_held_next[7:0]      = d;
            4'd5:    rate_held_next[15:8]     = d;
            4'd6:    rate_held_next[23:16]    = d;
            4'd7:    rate_held_next[31:24]    = d;
            4'd14:   width_held_next[7:0]     = d;
            4'd15:   width_held_next[15:8]    = d;
            default: ;
          endcase
          if (cur_cnt == 4'd15) begin
            cnt_next   = '0;
            phase_next = (cur_skip != '0) ? PH_SKIP : PH_HDR;
          end else begin
            cnt_next = cur_cnt + 4'd1;
          end
        end
        PH_SKIP: begin
          skip_left_next = cur_skip - 32'd1;
          if (skip_left_next == '0) begin
            phase_next = PH_HDR;
            cnt_next   = '0;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (!found && req.item.last_byte) begin
        fail = 1'b1;
      end
      if (found || fail) begin
        finished_next = 1'b1;
      end
    end
  end

  always_comb begin
    rsp.res_valid = found || fail;
    if (found) begin
      rsp.res.status      = STATUS_FOUND;
      rsp.res.channels    = channels_held_next;
      rsp.res.rate_hz     = rate_held_next;
      rsp.res.sample_bits = width_held_next;
      rsp.res.chunk_bytes = size_accum_next;
      rsp.res.payload_pos = file_position_next;
    end else begin
      rsp.res = '0;
      rsp.res.status = STATUS_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RIFF;
      cnt           <= '0;
      tag_shift     <= '0;
      size_accum    <= '0;
      skip_left     <= '0;
      channels_held <= '0;
      rate_held     <= '0;
      width_held    <= '0;
      file_position <= '0;
      finished      <= 1'b0;
    end else if (req.step) begin
      phase         <= phase_next;
      cnt           <= cnt_next;
      tag_shift     <= tag_shift_next;
      size_accum    <= size_accum_next;
      skip_left     <= skip_left_next;
      channels_held <= channels_held_next;
      rate_held     <= rate_held_next;
      width_held    <= width_held_next;
      file_position <= file_position_next;
      finished      <= finished_next;
    end
  end

endmodule

// File: src/wav_header_chunk_parser_top.sv
// A request is captured in the input register, and the result it causes is registered in the output register.
// Throughput: one request per cycle while no result waits for out_ready; each byte updates the parse state as it steps.
// A result that waits for out_ready holds the next request in the input register,
// and input then stops until the result is taken.
// Reset is synchronous and active high; it empties both registers and restarts the
// parse as if a new file began.
module wav_header_chunk_parser_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  wavhdr_pkg::wavhdr_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output wavhdr_pkg::wavhdr_out_t out_data
);
  import wavhdr_pkg::*;

  logic        s1_valid;
  wavhdr_in_t  s1_data;
  logic        advance;
  wavhdr_req_t core_req;
  wavhdr_rsp_t core_rsp;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  assign core_req.step = s1_valid && advance;
  assign core_req.item = s1_data;

  wavhdr_core u_core (
    .clk (clk),
    .rst (rst),
    .req (core_req),
    .rsp (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= core_req.step && core_rsp.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_req.step && core_rsp.res_valid) begin
      out_data <= core_rsp.res;
    end
  end

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_FAIL |->
      out_data.channels == '0 && out_data.rate_hz == '0 &&
      out_data.sample_bits == '0 && out_data.chunk_bytes == '0 &&
      out_data.payload_pos == '0)
    else $error("Fail result carries nonzero fields.");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("Input stalled with an empty input register.");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !in_ready |=> s1_valid && $stable(s1_data))
    else $error("Stalled request lost from the input register.");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import wavhdr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef enum {V_NONE, V_FOUND, V_FAIL} verdict_t;
  typedef enum {FL_NONE, FL_RIFF, FL_WAVE, FL_SHORT_FMT, FL_TRUNC, FL_RESTART} flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  wavhdr_in_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  wavhdr_out_t out_data;

  wav_header_chunk_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  wavhdr_in_t  byte_q[$];
  wavhdr_out_t expected_headers[$];
  logic [7:0]  file_bytes[$];

  int n_items = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  bit req_fire = 1'b0;
  bit rsp_fire = 1'b0;
  bit hit;
  wavhdr_out_t header_out;
  int burst_left = 0;
  int gap_left = 0;
  int pat_age = 0;
  int pat_sel;
  logic [15:0] ready_pat = '1;

  // Parser state mirror.
  phase_t      ph;
  logic [3:0]  step_cnt;
  logic [31:0] tag_reg;
  logic [31:0] size_reg;
  logic [31:0] skip_reg;
  logic [15:0] chans_reg;
  logic [31:0] rate_reg;
  logic [15:0] bits_reg;
  logic [31:0] pos_reg;
  logic        done_reg;

  function automatic void clear_parse();
    ph = PH_RIFF;
    step_cnt = '0;
    tag_reg = '0;
    size_reg = '0;
    skip_reg = '0;
    chans_reg = '0;
    rate_reg = '0;
    bits_reg = '0;
    pos_reg = '0;
    done_reg = 1'b0;
  endfunction

  function automatic void parse_wav_byte(input wavhdr_in_t b, output bit found,
                                         output wavhdr_out_t r);
    logic [3:0]  cnt;
    logic [31:0] offs;
    logic [7:0]  d;
    verdict_t    verdict;
    found = 1'b0;
    r = '0;
    verdict = V_NONE;
    d = b.data_byte;
    if (b.first_byte) clear_parse();
    if (done_reg) return;
    pos_reg = pos_reg + 32'd1;
    offs = pos_reg;
    cnt = step_cnt;
    case (ph)
      PH_RIFF: begin
        tag_reg = {tag_reg[23:0], d};
        if (cnt == 4'd3 && tag_reg != TAG_RIFF) begin
          verdict = V_FAIL;
        end else if (cnt == 4'd11) begin
          if (tag_reg != TAG_WAVE) begin
            verdict = V_FAIL;
          end else begin
            ph = PH_HDR;
            cnt = '0;
          end
        end else begin
          cnt = cnt + 4'd1;
        end
      end
      PH_HDR: begin
        if (cnt < 4'd4) tag_reg = {tag_reg[23:0], d};
        else size_reg = {d, size_reg[31:8]};
        if (cnt == 4'd7) begin
          cnt = '0;
          if (tag_reg == TAG_FMT) begin
            if (size_reg < FMT_MIN) begin
              verdict = V_FAIL;
            end else begin
              skip_reg = size_reg - FMT_MIN;
              ph = PH_FMT;
            end
          end else if (tag_reg == TAG_DATA) begin
            verdict = V_FOUND;
          end else if (size_reg != 32'd0) begin
            skip_reg = size_reg;
            ph = PH_SKIP;
          end
        end else begin
          cnt = cnt + 4'd1;
        end
      end
      PH_FMT: begin
        case (cnt)
          4'd2:  chans_reg[7:0] = d;
          4'd3:  chans_reg[15:8] = d;
          4'd4:  rate_reg[7:0] = d;
          4'd5:  rate_reg[15:8] = d;
          4'd6:  rate_reg[23:16] = d;
          4'd7:  rate_reg[31:24] = d;
          4'd14: bits_reg[7:0] = d;
          4'd15: bits_reg[15:8] = d;
          default: ;
        endcase
        if (cnt == 4'd15) begin
          cnt = '0;
          ph = (skip_reg != 32'd0) ? PH_SKIP : PH_HDR;
        end else begin
          cnt = cnt + 4'd1;
        end
      end
      PH_SKIP: begin
        skip_reg = skip_reg - 32'd1;
        if (skip_reg == 32'd0) begin
          ph = PH_HDR;
          cnt = '0;
        end
      end
      default: verdict = V_FAIL;
    endcase
    step_cnt = cnt;
    if (verdict == V_NONE && b.last_byte) verdict = V_FAIL;
    if (verdict != V_NONE) begin
      done_reg = 1'b1;
      found = 1'b1;
      if (verdict == V_FOUND) begin
        r.status = STATUS_FOUND;
        r.channels = chans_reg;
        r.rate_hz = rate_reg;
        r.sample_bits = bits_reg;
        r.chunk_bytes = size_reg;
        r.payload_pos = offs;
      end else begin
        r.status = STATUS_FAIL;
      end
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void push_item(input logic [7:0] d, input bit f, input bit l);
    wavhdr_in_t b;
    b.data_byte = d;
    b.first_byte = f;
    b.last_byte = l;
    byte_q.push_back(b);
    n_items++;
  endfunction

  function automatic void put_be(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_le(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_fill(input logic [7:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v);
  endfunction

  function automatic void put_rand(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom()));
  endfunction

  function automatic void put_wav_head();
    file_bytes = {};
    put_be(TAG_RIFF);
    put_le($urandom());
    put_be(TAG_WAVE);
  endfunction

  function automatic void emit_file(input bit with_first, input bit with_last);
    int n;
    n = file_bytes.size();
    for (int i = 0; i < n; i++)
      push_item(file_bytes[i], with_first && i == 0, with_last && i == n - 1);
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic void make_file(input flaw_t flaw);
    int n_chunks;
    int len;
    int cut;
    int p;
    logic [31:0] id;
    put_wav_head();
    n_chunks = $urandom_range(0, 2);
    if (flaw == FL_SHORT_FMT) begin
      put_be(TAG_FMT);
      put_le($urandom_range(0, 15));
      put_rand(16);
    end
    for (int c = 0; c < n_chunks; c++) begin
      if ($urandom_range(0, 1) == 1) begin
        len = 16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
        put_be(TAG_FMT);
      end else begin
        id = $urandom();
        if (id == TAG_FMT || id == TAG_DATA) id = id ^ 32'h1;
        len = $urandom_range(0, 6);
        put_be(id);
      end
      put_le(len);
      put_rand(len);
    end
    put_be(TAG_DATA);
    put_le(pick32());
    put_rand($urandom_range(0, 3));
    case (flaw)
      FL_RIFF: begin
        p = $urandom_range(0, 3);
        file_bytes[p] = file_bytes[p] ^ 8'($urandom_range(1, 255));
      end
      FL_WAVE: begin
        p = $urandom_range(8, 11);
        file_bytes[p] = file_bytes[p] ^ 8'($urandom_range(1, 255));
      end
      FL_TRUNC, FL_RESTART: begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
      default: ;
    endcase
    emit_file(1'b1, flaw != FL_RESTART && $urandom_range(0, 9) != 0);
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_data <= byte_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern, changed every so often.
  always @(negedge clk) begin
    if (pat_age == 0) begin
      pat_age = $urandom_range(20, 120);
      pat_sel = $urandom_range(0, 3);
      if (pat_sel == 0) ready_pat = '1;
      else if (pat_sel == 1) ready_pat = 16'($urandom()) | 16'h0001;
      else if (pat_sel == 2) ready_pat = 16'h8000;
      else ready_pat = (16'($urandom()) & 16'($urandom())) | 16'h0001;
    end
    pat_age--;
    out_ready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
  end

  // Prediction, result checking and the watchdog.
  always @(posedge clk) begin
    req_fire = !rst && in_valid && in_ready;
    rsp_fire = !rst && out_valid && out_ready;
    if (req_fire) begin
      parse_wav_byte(in_data, hit, header_out);
      if (hit) expected_headers.push_back(header_out);
    end
    if (rsp_fire) begin
      if (expected_headers.size() == 0) begin
        $error("result with no request pending: status %0b", out_data.status);
        n_errors++;
      end else begin
        header_out = expected_headers.pop_front();
        cmp_field("status", 32'(header_out.status), 32'(out_data.status));
        cmp_field("channels", 32'(header_out.channels), 32'(out_data.channels));
        cmp_field("rate_hz", header_out.rate_hz, out_data.rate_hz);
        cmp_field("sample_bits", 32'(header_out.sample_bits), 32'(out_data.sample_bits));
        cmp_field("chunk_bytes", header_out.chunk_bytes, out_data.chunk_bytes);
        cmp_field("payload_pos", header_out.payload_pos, out_data.payload_pos);
      end
    end
    if (rst || req_fire || rsp_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    clear_parse();

    // A file with no start mark right after reset, then a stray byte after its result.
    file_bytes = {};
    put_be(TAG_RIFF);
    put_le(32'h0);
    put_be(TAG_WAVE);
    put_be(TAG_DATA);
    put_le(32'h0);
    emit_file(1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);

    // A file of one byte.
    push_item(8'h00, 1'b1, 1'b1);

    // Bad RIFF tag, then bad WAVE tag.
    file_bytes = {};
    put_be(TAG_RIFF ^ 32'h1);
    put_le(32'h0);
    put_be(TAG_WAVE);
    emit_file(1'b1, 1'b1);
    put_wav_head();
    file_bytes[8] = file_bytes[8] ^ 8'h80;
    put_be(TAG_DATA);
    emit_file(1'b1, 1'b1);

    // Fields at their maximum, extra fmt bytes, an empty chunk and an odd-sized one.
    put_wav_head();
    put_be(TAG_FMT);
    put_le(32'd17);
    put_fill(8'hFF, 17);
    put_be(32'h4A554E4B);
    put_le(32'h0);
    put_be(32'h4C495354);
    put_le(32'd3);
    put_fill(8'h00, 3);
    put_be(TAG_DATA);
    put_le(32'hFFFF_FFFF);
    put_fill(8'h00, 2);
    emit_file(1'b1, 1'b1);

    // A fmt chunk one byte too short.
    put_wav_head();
    put_be(TAG_FMT);
    put_le(32'd15);
    put_fill(8'h00, 15);
    emit_file(1'b1, 1'b1);

    // The file ends inside a chunk header.
    put_wav_head();
    put_be(32'h4C495354);
    emit_file(1'b1, 1'b1);

    // A new file starts in the middle of the previous one.
    file_bytes = {};
    put_be(TAG_RIFF);
    put_le(32'h0);
    emit_file(1'b1, 1'b0);
    put_wav_head();
    put_be(TAG_FMT);
    put_le(32'd16);
    put_fill(8'h00, 16);
    put_be(TAG_DATA);
    put_le(32'h8000_0001);
    emit_file(1'b1, 1'b1);

    // Hold off until the directed results are all back.
    do @(negedge clk);
    while (byte_q.size() != 0 || in_valid || expected_headers.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    while (n_items < 1450) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        make_file(FL_NONE);
      end else if (k < 66) begin
        make_file(FL_RIFF);
      end else if (k < 72) begin
        make_file(FL_WAVE);
      end else if (k < 78) begin
        make_file(FL_SHORT_FMT);
      end else if (k < 86) begin
        make_file(FL_TRUNC);
      end else if (k < 92) begin
        make_file(FL_RESTART);
      end else begin
        for (int i = $urandom_range(1, 12); i > 0; i--)
          push_item(8'($urandom()), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      end
    end

    do @(negedge clk);
    while (byte_q.size() != 0 || in_valid || expected_headers.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

endmodule

// File: sim.f
src/wavhdr_pkg.sv
src/wavhdr_core.sv
src/wav_header_chunk_parser_top.sv
tb/tb.sv
